[design/sobel_edge_magnitude_3x3_top_defines.svh]
// assertion macros for the sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_TOP_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_TOP_DEFINES_SVH

// antecedent holds, consequent in the same cycle
`define SBL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds, consequent in the next cycle
`define SBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sbl_pkg.sv]
// shared types and constants for the sobel edge magnitude block
`default_nettype none

package sbl_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int PIX_W      = 8;
    localparam int LINE_W     = 2 * PIX_W;
    localparam int WREG_W     = 11;
    localparam int HREG_W     = 16;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 16;
    localparam int ABS_W      = 10;
    localparam int SUMSQ_W    = 21;
    localparam int ROOT_W     = 17;
    localparam int ROOT_STEPS = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HREG_W-1:0] HEIGHT_RESET = 16'd480;
    localparam logic [PIX_W-1:0]  MAG_SAT      = 8'd255;
    localparam logic [SUMSQ_W-1:0] ROOT_LIMIT  = 21'd65536;
    localparam logic [ROOT_W-1:0]  ROOT_BIT0   = 17'h04000;

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_CALC,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SUM,
        SQ_ITER,
        SQ_DONE
    } t_sq_state;

    typedef struct packed {
        logic             start;
        logic [ABS_W-1:0] ax;
        logic [ABS_W-1:0] ay;
    } t_sq_req;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] mag;
    } t_sq_rsp;

endpackage

`default_nettype wire

[design/sbl_line_mem.sv]
// line buffer ram holding the two previous rows side by side
`default_nettype none

module sbl_line_mem #(
    parameter int DEPTH = sbl_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(sbl_pkg::MAX_WIDTH_DEF)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rd_en,
    input  wire logic [AW-1:0]             i_rd_addr,
    output logic      [sbl_pkg::LINE_W-1:0] o_rd_data,
    input  wire logic                      i_wr_en,
    input  wire logic [AW-1:0]             i_wr_addr,
    input  wire logic [sbl_pkg::LINE_W-1:0] i_wr_data
);
    import sbl_pkg::*;

    logic [LINE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/sbl_isqrt.sv]
// squares the two gradients and takes the integer root two bits a step
`default_nettype none

module sbl_isqrt (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sbl_pkg::t_sq_req i_req,
    output sbl_pkg::t_sq_rsp      o_rsp
);
    import sbl_pkg::*;

    t_sq_state           r_state, n_state;
    logic [ABS_W-1:0]    r_ax, r_ay;
    logic [ROOT_W-1:0]   r_v, r_res, r_bit;
    logic                r_sat;
    logic [2:0]          r_step;
    logic [SUMSQ_W-1:0]  sum_sq;
    logic [ROOT_W-1:0]   trial;
    logic                last_step;

    assign sum_sq    = SUMSQ_W'(r_ax) * SUMSQ_W'(r_ax) + SUMSQ_W'(r_ay) * SUMSQ_W'(r_ay);
    assign trial     = r_res + r_bit;
    assign last_step = (r_step == 3'(ROOT_STEPS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            SQ_IDLE: if (i_req.start) n_state = SQ_SUM;
            SQ_SUM:  n_state = SQ_ITER;
            SQ_ITER: if (last_step) n_state = SQ_DONE;
            SQ_DONE: n_state = SQ_IDLE;
            default: n_state = SQ_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_state == SQ_DONE);
        o_rsp.mag  = r_sat ? MAG_SAT : r_res[PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SQ_IDLE: begin
                if (i_req.start) begin
                    r_ax <= i_req.ax;
                    r_ay <= i_req.ay;
                end
            end
            SQ_SUM: begin
                r_sat  <= (sum_sq >= ROOT_LIMIT);
                r_v    <= ROOT_W'(sum_sq);
                r_res  <= '0;
                r_bit  <= ROOT_BIT0;
                r_step <= '0;
            end
            SQ_ITER: begin
                if (r_v >= trial) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_step <= r_step + 3'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[design/sobel_edge_magnitude_3x3_top.sv]
// sobel edge magnitude top: position counters, 3x3 window, line ram, output stage
// border pixel: accept, ram read, window update, then back to idle for the next pixel
// interior pixel: after the window update the 8-step square-root unit runs, and the
//   result loads into the output register once free or being read, then back to idle
// a result waiting in the output register does not stop the next input transfer
// synchronous active-low reset clears counters, window, fsm and output valid;
//   line ram contents are undefined until written, no clearing pass
`default_nettype none

module sobel_edge_magnitude_3x3_top #(
    parameter int MAX_WIDTH = sbl_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // apb configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sbl_pkg::APB_AW-1:0]    paddr,
    input  wire logic [sbl_pkg::APB_DW-1:0]    pwdata,
    output logic      [sbl_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    // pixel input
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [sbl_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [7:0] pixel
    input  wire logic                          s_axis_tuser,  // [0] frame_start
    // magnitude output
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [7:0] magnitude, [17:8] col, [33:18] row, [39:34] zero
    output logic      [sbl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                               m_axis_tlast
);
    import sbl_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (WW > WREG_W) ? WW : WREG_W;

    // configuration
    logic [WREG_W-1:0] r_width;
    logic [HREG_W-1:0] r_height;
    logic              cfg_wr;
    logic [EW-1:0]     eff_w, w_ext;
    logic [HREG_W-1:0] eff_h;

    // position and item
    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt_c, r_c;
    logic [ROW_W-1:0]  r_cnt_r;
    logic [PIX_W-1:0]  r_px;
    logic              r_interior, r_last;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [PIX_W-1:0]  r_win [9];

    logic              in_xfer, out_load;
    logic [CW-1:0]     cur_c;
    logic [ROW_W-1:0]  cur_r;
    logic [EW-1:0]     c_ext, c_inc, c_m1;
    logic [ROW_W:0]    r_inc;

    // ram and root unit
    logic [LINE_W-1:0] rd_data;
    logic [PIX_W-1:0]  top_px, mid_px;
    logic              mem_rd, mem_wr;
    t_sq_req           sq_req;
    t_sq_rsp           sq_rsp;

    logic [PIX_W+1:0]  sx_pos, sx_neg, sy_pos, sy_neg;
    logic signed [PIX_W+3:0] gx, gy;

    // output stage
    logic                   r_m_valid, r_m_last;
    logic [OUT_TDATA_W-1:0] r_m_data;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_height);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_IMAGE_WIDTH) begin
                r_width <= pwdata[WREG_W-1:0];
            end else begin
                r_height <= pwdata[HREG_W-1:0];
            end
        end
    end

    // clamp width to 3..MAX_WIDTH, height to at least 3
    always_comb begin
        w_ext = EW'(r_width);
        if (w_ext < EW'(3)) begin
            eff_w = EW'(3);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = w_ext;
        end
        eff_h = (r_height < HREG_W'(3)) ? HREG_W'(3) : r_height;
    end

    // ---------------- position of the incoming pixel ----------------
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign cur_c   = s_axis_tuser ? '0 : r_cnt_c;
    assign cur_r   = s_axis_tuser ? '0 : r_cnt_r;
    assign c_ext   = EW'(cur_c);
    assign c_inc   = c_ext + EW'(1);
    assign c_m1    = c_ext - EW'(1);
    assign r_inc   = {1'b0, cur_r} + 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_c <= '0;
            r_cnt_r <= '0;
        end else if (in_xfer) begin
            if (c_inc >= eff_w) begin
                r_cnt_c <= '0;
                r_cnt_r <= (r_inc >= {1'b0, eff_h}) ? '0 : r_inc[ROW_W-1:0];
            end else begin
                r_cnt_c <= c_inc[CW-1:0];
                r_cnt_r <= cur_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_px       <= s_axis_tdata[PIX_W-1:0];
            r_c        <= cur_c;
            r_col      <= COL_W'(c_m1);
            r_row      <= cur_r - ROW_W'(1);
            r_interior <= (c_ext >= EW'(2)) && (cur_r >= ROW_W'(2))
                          && (c_ext < eff_w) && (cur_r < eff_h);
            r_last     <= (c_ext == eff_w - EW'(1)) && (cur_r == eff_h - HREG_W'(1));
        end
    end

    // ---------------- control fsm ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_xfer) n_state = ST_READ;
            ST_READ:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = r_interior ? ST_CALC : ST_IDLE;
            ST_CALC:   if (sq_rsp.done) n_state = ST_OUT;
            ST_OUT:    if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        mem_rd        = (r_state == ST_READ);
        mem_wr        = (r_state == ST_UPDATE);
        out_load      = (r_state == ST_OUT) && (!r_m_valid || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- line ram: upper byte previous row, lower byte the one before ----
    sbl_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd),
        .i_rd_addr (r_c),
        .o_rd_data (rd_data),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_c),
        .i_wr_data ({r_px, mid_px})
    );

    assign mid_px = rd_data[LINE_W-1:PIX_W];
    assign top_px = rd_data[PIX_W-1:0];

    // ---------------- window and gradients ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (mem_wr) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= top_px;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= mid_px;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= r_px;
        end
    end

    // sums use the window after this shift
    always_comb begin
        sx_pos = 10'(top_px) + {1'b0, mid_px, 1'b0} + 10'(r_px);
        sx_neg = 10'(r_win[1]) + {1'b0, r_win[4], 1'b0} + 10'(r_win[7]);
        sy_pos = 10'(r_win[1]) + {1'b0, r_win[2], 1'b0} + 10'(top_px);
        sy_neg = 10'(r_win[7]) + {1'b0, r_win[8], 1'b0} + 10'(r_px);
        gx = $signed({2'b00, sx_pos}) - $signed({2'b00, sx_neg});
        gy = $signed({2'b00, sy_pos}) - $signed({2'b00, sy_neg});
        sq_req.start = (r_state == ST_UPDATE) && r_interior;
        sq_req.ax = gx[PIX_W+3] ? ABS_W'(-gx) : ABS_W'(gx);
        sq_req.ay = gy[PIX_W+3] ? ABS_W'(-gy) : ABS_W'(gy);
    end

    sbl_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= OUT_TDATA_W'({r_row, r_col, sq_rsp.mag});
            r_m_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire

[design/sbl_checker.sv]
// port-level checks for the sobel edge magnitude block, bound to the top level
`default_nettype none
`include "sobel_edge_magnitude_3x3_top_defines.svh"

module sbl_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [sbl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire logic                             m_axis_tlast
);
    import sbl_pkg::*;

    `SBL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")
    `SBL_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while item in progress")
    `SBL_ASSERT_SAME(a_row_interior, m_axis_tvalid, m_axis_tdata[33:18] != 16'd0, "result row on the top border")
    `SBL_ASSERT_SAME(a_out_from_busy, $rose(m_axis_tvalid), !$past(s_axis_tready), "result appeared without an item in work")

endmodule

bind sobel_edge_magnitude_3x3_top sbl_checker u_sbl_checker (.*);

`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the sobel edge magnitude block
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sbl_pkg::*;

    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [PIX_W-1:0] mag;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_edge_px;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [APB_DW-1:0]      pwdata = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] pixel
    logic                   s_axis_tuser = 1'b0; // [0] frame_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [7:0] mag, [17:8] col, [33:18] row
    logic                   m_axis_tlast;

    // own copy of the block state
    logic [PIX_W-1:0]  line_a [MAX_WIDTH_DEF] = '{default: '0};
    logic [PIX_W-1:0]  line_b [MAX_WIDTH_DEF] = '{default: '0};
    logic [PIX_W-1:0]  win [9] = '{default: '0};
    int unsigned       col_pos = 0;
    int unsigned       row_pos = 0;
    logic [WREG_W-1:0] cfg_width = WIDTH_RESET;
    logic [HREG_W-1:0] cfg_height = HEIGHT_RESET;

    t_edge_px    edge_expect_q[$];
    int unsigned err_count = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned reg_writes = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          hold_len = 0;
    logic        sink_hold = 1'b0;

    sobel_edge_magnitude_3x3_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    function automatic int unsigned eff_width();
        if (cfg_width < 3) return 3;
        if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height < 3) return 3;
        return cfg_height;
    endfunction

    task automatic note_mismatch(input string msg);
        if (err_count < 10) $display("tb_top: mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // advance the window by one pixel and queue the edge result it produces
    task automatic predict_edge(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned w, h, c, r, idx, s, m, t;
        int gx, gy;
        logic [PIX_W-1:0] top, mid;
        t_edge_px res;
        w = eff_width();
        h = eff_height();
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        idx = (c < MAX_WIDTH_DEF) ? c : MAX_WIDTH_DEF - 1;
        top = line_b[idx];
        mid = line_a[idx];
        line_b[idx] = mid;
        line_a[idx] = pix;
        win[0] = win[1]; win[1] = win[2]; win[2] = top;
        win[3] = win[4]; win[4] = win[5]; win[5] = mid;
        win[6] = win[7]; win[7] = win[8]; win[8] = pix;
        if (c >= 2 && r >= 2 && c < w && r < h) begin
            gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
               - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
            gy = (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]))
               - (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]));
            if (gx < 0) gx = -gx;
            if (gy < 0) gy = -gy;
            s = gx * gx + gy * gy;
            m = 0;
            if (s >= 65536) begin
                m = 255;
            end else begin
                // root bit by bit, msb first
                for (int b = 7; b >= 0; b--) begin
                    t = m | (1 << b);
                    if (t * t <= s) m = t;
                end
            end
            res.mag  = m[PIX_W-1:0];
            res.col  = COL_W'(c - 1);
            res.row  = ROW_W'(r - 1);
            res.last = (c == w - 1 && r == h - 1);
            edge_expect_q.push_back(res);
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        while (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= fs;
        predict_edge(pix, fs);
        items_sent++;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input int kind);
        case (kind)
            0: return PIX_W'($urandom_range(255, 0));
            1: return $urandom_range(1, 0) ? 8'd255 : 8'd0;
            default: return PIX_W'($urandom_range(140, 116));
        endcase
    endfunction

    task automatic send_frame(input int unsigned count, input logic first_fs,
                              input int kind, input int noise_pct);
        for (int unsigned k = 0; k < count; k++) begin
            send_pixel(pick_pixel(kind),
                       (k == 0) ? first_fs : ($urandom_range(99, 0) < noise_pct));
        end
    endtask

    // drain every expected result, then let the last border pixel finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (edge_expect_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reg_read_check(input logic idx, input logic [APB_DW-1:0] want);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            note_mismatch($sformatf("register %0d read expected %0d got %0d", idx, want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_IMAGE_WIDTH) cfg_width = val[WREG_W-1:0];
        else cfg_height = val[HREG_W-1:0];
        reg_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        psel    <= 1'b0;
        @(posedge i_clk);
        reg_read_check(idx, (idx == REG_IMAGE_WIDTH) ? APB_DW'(cfg_width) : APB_DW'(cfg_height));
    endtask

    task automatic set_size(input logic [APB_DW-1:0] w, input logic [APB_DW-1:0] h);
        settle();
        reg_write(REG_IMAGE_WIDTH, w);
        reg_write(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic test_reset_values();
        reg_read_check(REG_IMAGE_WIDTH, APB_DW'(WIDTH_RESET));
        reg_read_check(REG_IMAGE_HEIGHT, APB_DW'(HEIGHT_RESET));
    endtask

    // 3x3 frames: saturated vertical edge, near-limit mix, tiny values via frame wrap
    task automatic test_directed();
        logic [PIX_W-1:0] pics [27] = '{
            8'd0,  8'd0,  8'd255, 8'd0,  8'd0,  8'd255, 8'd0,  8'd0,  8'd255,
            8'd10, 8'd20, 8'd30,  8'd40, 8'd50, 8'd60,  8'd70, 8'd80, 8'd90,
            8'd3,  8'd0,  8'd0,   8'd0,  8'd0,  8'd0,   8'd0,  8'd0,  8'd0
        };
        src_idle_pct = 0;
        sink_stall_pct = 0;
        set_size(3, 3);
        for (int k = 0; k < 27; k++) begin
            // third frame has no frame start, it follows from the counter wrap
            send_pixel(pics[k], (k == 0 || k == 9));
        end
    endtask

    task automatic test_size_extremes();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        set_size(0, 0);
        send_frame(9, 1'b1, 0, 0);
        // height below the minimum clamps to three rows
        set_size(30, 2);
        send_frame(3 * 30, 1'b1, 0, 0);
        set_size(4, 65535);
        send_frame(28, 1'b1, 0, 0);
    endtask

    task automatic test_shrink_midframe();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        set_size(12, 8);
        send_frame(2 * 12 + 9, 1'b1, 0, 0);
        // column counter now beyond the new width: row ends after one pixel
        settle();
        reg_write(REG_IMAGE_WIDTH, 5);
        send_frame(1 + 2 * 5, 1'b0, 0, 0);
        // row counter beyond the new height: frame wraps at the row end
        settle();
        reg_write(REG_IMAGE_HEIGHT, 4);
        send_frame(5, 1'b0, 0, 0);
        send_frame(20, 1'b0, 0, 0);
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        set_size(16, 6);
        hold_len <= HOLD_CYCLES;
        send_frame(96, 1'b1, 0, 0);
    endtask

    task automatic test_random(input int src_pct, input int sink_pct, input int unsigned n_items);
        int unsigned first_item, len;
        logic fresh;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        first_item = items_sent;
        fresh = 1'b1;
        set_size($urandom_range(12, 3), $urandom_range(8, 3));
        while (items_sent - first_item < n_items) begin
            if ($urandom_range(3, 0) == 0) begin
                set_size(($urandom_range(9, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(12, 3),
                         ($urandom_range(6, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(8, 3));
                fresh = 1'b1;
            end
            len = eff_width() * eff_height();
            // some frames are cut short
            if ($urandom_range(7, 0) == 0) len = $urandom_range(len - 1, 1);
            // after a size change the frame must restart, else it may run on
            send_frame(len, fresh || ($urandom_range(5, 0) != 0), $urandom_range(2, 0), 1);
            fresh = 1'b0;
        end
    endtask

    // output side: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= !sink_hold && ($urandom_range(99, 0) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (hold_len != 0) begin
            sink_hold <= 1'b1;
            hold_len  <= hold_len - 1;
        end else begin
            sink_hold <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_edge_px want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (edge_expect_q.size() == 0) begin
                note_mismatch($sformatf("unexpected result mag %0d col %0d row %0d last %0d",
                    m_axis_tdata[7:0], m_axis_tdata[17:8], m_axis_tdata[33:18], m_axis_tlast));
            end else begin
                want = edge_expect_q.pop_front();
                if (m_axis_tdata[7:0] !== want.mag || m_axis_tdata[17:8] !== want.col ||
                    m_axis_tdata[33:18] !== want.row || m_axis_tlast !== want.last ||
                    m_axis_tdata[OUT_TDATA_W-1:34] !== '0)
                    note_mismatch($sformatf(
                        "mag/col/row/last expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d pad %0h",
                        want.mag, want.col, want.row, want.last,
                        m_axis_tdata[7:0], m_axis_tdata[17:8], m_axis_tdata[33:18], m_axis_tlast,
                        m_axis_tdata[OUT_TDATA_W-1:34]));
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_directed();
        test_size_extremes();
        test_shrink_midframe();
        test_backpressure();
        test_random(0, 0, 183);
        test_random(51, 0, 183);
        test_random(0, 51, 183);
        test_random(24, 24, 183);
        settle();
        $display("tb_top: %0d pixels sent, %0d edge results checked, %0d register writes",
                 items_sent, results_seen, reg_writes);
        $display("tb_top: sizes 3x3 to 30 wide, clamped sizes, mid-frame shrink, frame wrap, %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (err_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: %0d mismatches", err_count);
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_top: timeout, %0d results still expected", edge_expect_q.size());
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
